@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the token tuple window generator.
// No dependencies; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the clock edge that follows the trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/ttw_pkg.sv @@
// Package for the token tuple window generator: sizes, register indexes and shared types.
// No dependencies; used by every RTL module of the block.
package ttw_pkg;

	// Number of tokens held in the window (2 to 8).
	localparam int WINDOW_LEN = 8;

	localparam int CODE_W  = 8;
	localparam int VALUE_W = 16;
	localparam int POS_W   = 32;
	localparam int LINE_W  = 24;
	localparam int TUPLE_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int FILL_W  = $clog2(WINDOW_LEN + 1);

	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FILENAME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEWLINE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LABEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTVAL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHARCONST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRINGLIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILENUM   = 3'd6;

	// Contents of one window cell.
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic [LINE_W-1:0]  line;
	} cell_data_t;

	// Classification of the token on the input channel.
	typedef struct packed {
		logic is_name;
		logic is_line;
		logic keep_value;
	} tok_class_t;

endpackage

@@ rtl/ttw_cfg_regs.sv @@
// Configuration registers and token classifier of the token tuple window generator.
// Depends on ttw_pkg.
module ttw_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [ttw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttw_pkg::CODE_W-1:0]          cfg_data,
	input  logic [ttw_pkg::CODE_W-1:0]          token_kind,
	output ttw_pkg::tok_class_t                 tok_class,
	output logic [ttw_pkg::CODE_W-1:0]          file_number
);

	logic [ttw_pkg::CODE_W-1:0] filename_q, newline_q, label_q, intval_q;
	logic [ttw_pkg::CODE_W-1:0] charconst_q, stringlit_q, filenum_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filename_q  <= 8'd1;
			newline_q   <= 8'd2;
			label_q     <= 8'd3;
			intval_q    <= 8'd4;
			charconst_q <= 8'd5;
			stringlit_q <= 8'd6;
			filenum_q   <= 8'd0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ttw_pkg::REG_FILENAME:  filename_q  <= cfg_data;
				ttw_pkg::REG_NEWLINE:   newline_q   <= cfg_data;
				ttw_pkg::REG_LABEL:     label_q     <= cfg_data;
				ttw_pkg::REG_INTVAL:    intval_q    <= cfg_data;
				ttw_pkg::REG_CHARCONST: charconst_q <= cfg_data;
				ttw_pkg::REG_STRINGLIT: stringlit_q <= cfg_data;
				ttw_pkg::REG_FILENUM:   filenum_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A file-name match wins over a line match; values are kept for four codes.
	always_comb begin
		tok_class.is_name    = (token_kind == filename_q);
		tok_class.is_line    = (token_kind != filename_q) && (token_kind == newline_q);
		tok_class.keep_value = (token_kind == label_q) || (token_kind == intval_q) ||
			(token_kind == charconst_q) || (token_kind == stringlit_q);
	end

	assign file_number = filenum_q;

endmodule

@@ rtl/ttw_cell.sv @@
// One cell of the token window: holds a code, a value, a stream position and a line.
// Depends on ttw_pkg.
module ttw_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic                clear,
	input  ttw_pkg::cell_data_t d_in,
	output ttw_pkg::cell_data_t q_out
);

	logic [ttw_pkg::CODE_W-1:0]  code_q;
	logic [ttw_pkg::VALUE_W-1:0] value_q;
	logic [ttw_pkg::POS_W-1:0]   position_q;
	logic [ttw_pkg::LINE_W-1:0]  line_q;

	// Code and value start at zero and are cleared by a file-name token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q  <= '0;
			value_q <= '0;
		end else if (clear) begin
			code_q  <= '0;
			value_q <= '0;
		end else if (shift_en) begin
			code_q  <= d_in.code;
			value_q <= d_in.value;
		end
	end

	// Position and line are always written before they are read.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			position_q <= d_in.position;
			line_q     <= d_in.line;
		end
	end

	assign q_out.code     = code_q;
	assign q_out.value    = value_q;
	assign q_out.position = position_q;
	assign q_out.line     = line_q;

endmodule

@@ rtl/token_tuple_window_generator_unit.sv @@
// Top level of the token tuple window generator: a chain of window cells, file and
// line tracking, and the result register. Depends on ttw_pkg, ttw_cfg_regs, ttw_cell, assert_macros.svh.
//
// Channel   Direction  Handshake               Transaction
// in        input      in_valid / in_ready     one token: kind, value, position
// out       output     out_valid / out_ready   one window tuple and its origin
// cfg       input      cfg_wen                 one register write, no wait
//
// One token is accepted per cycle while in_ready is high; its result, if any, is valid in the next cycle.
// The cell chain shifts by one cell per ordinary token, so the oldest cell holds
// the position and line of the tuple start.
// Reset clears the window codes and values, counters and result valid; registers take their defaults.
// in_ready is low only while a result waits and out_ready is low.
`include "assert_macros.svh"

module token_tuple_window_generator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ttw_pkg::CODE_W-1:0]        token_kind,
	input  logic [31:0]                       token_value,
	input  logic [ttw_pkg::POS_W-1:0]         token_position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ttw_pkg::TUPLE_W-1:0]       tuple_codes,
	output logic [ttw_pkg::VALUE_W-1:0]       value_xor,
	output logic [ttw_pkg::POS_W-1:0]         start_position,
	output logic [ttw_pkg::LINE_W-1:0]        start_line,
	output logic [ttw_pkg::POS_W-1:0]         name_position,
	output logic [ttw_pkg::CODE_W-1:0]        file_tag,
	input  logic                              cfg_wen,
	input  logic [ttw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ttw_pkg::CODE_W-1:0]        cfg_data
);

	localparam int N = ttw_pkg::WINDOW_LEN;

	ttw_pkg::tok_class_t          tok_class;
	logic [ttw_pkg::CODE_W-1:0]   file_number;
	ttw_pkg::cell_data_t          cell_q [N];
	ttw_pkg::cell_data_t          new_cell;
	logic                         accept, name_tok, line_tok, ord_tok, emit;
	logic [ttw_pkg::FILL_W-1:0]   fill_q;
	logic [ttw_pkg::LINE_W-1:0]   line_q;
	logic [ttw_pkg::POS_W-1:0]    name_pos_q;
	logic                         out_valid_q;
	logic [ttw_pkg::TUPLE_W-1:0]  packed_next;
	logic [ttw_pkg::VALUE_W-1:0]  xor_next;
	logic [ttw_pkg::TUPLE_W-1:0]  tuple_q;
	logic [ttw_pkg::VALUE_W-1:0]  xor_q;
	logic [ttw_pkg::POS_W-1:0]    start_pos_q;
	logic [ttw_pkg::LINE_W-1:0]   start_line_q;
	logic [ttw_pkg::POS_W-1:0]    name_out_q;
	logic [ttw_pkg::CODE_W-1:0]   file_tag_q;

	// Configuration registers and classification of the incoming token.
	ttw_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.token_kind  (token_kind),
		.tok_class   (tok_class),
		.file_number (file_number)
	);

	// Handshake and token decode.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign name_tok = accept && tok_class.is_name;
	assign line_tok = accept && tok_class.is_line;
	assign ord_tok  = accept && !tok_class.is_name && !tok_class.is_line;
	assign emit     = ord_tok && (fill_q >= ttw_pkg::FILL_W'(N - 1));

	// Data entering the newest cell.
	always_comb begin
		new_cell.code     = token_kind;
		new_cell.value    = tok_class.keep_value ? token_value[ttw_pkg::VALUE_W-1:0] : '0;
		new_cell.position = token_position;
		new_cell.line     = line_q;
	end

	// Cell chain: cell 0 is the oldest, each cell takes its right neighbor.
	for (genvar g = 0; g < N; g++) begin : g_cell
		ttw_pkg::cell_data_t d_in;
		if (g == N - 1) begin : g_last
			assign d_in = new_cell;
		end else begin : g_mid
			assign d_in = cell_q[g+1];
		end
		ttw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (ord_tok),
			.clear    (name_tok),
			.d_in     (d_in),
			.q_out    (cell_q[g])
		);
	end

	// Window contents after this token has shifted in, oldest in the top byte.
	always_comb begin
		packed_next = '0;
		xor_next    = new_cell.value;
		packed_next[ttw_pkg::CODE_W-1:0] = new_cell.code;
		for (int i = 1; i < N; i++) begin
			packed_next[ttw_pkg::CODE_W*(N-i) +: ttw_pkg::CODE_W] = cell_q[i].code;
			xor_next = xor_next ^ cell_q[i].value;
		end
	end

	// Fill count, line counter and file-name offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			line_q     <= '0;
			name_pos_q <= '0;
		end else if (name_tok) begin
			fill_q     <= '0;
			line_q     <= ttw_pkg::LINE_W'(1);
			name_pos_q <= token_position;
		end else if (line_tok) begin
			if (line_q != ttw_pkg::LINE_MAX) begin
				line_q <= line_q + 1'b1;
			end
		end else if (ord_tok) begin
			if (fill_q != ttw_pkg::FILL_W'(N)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; the oldest entry after the shift is the current cell 1.
	always_ff @(posedge clk) begin
		if (emit) begin
			tuple_q      <= packed_next;
			xor_q        <= xor_next;
			start_pos_q  <= cell_q[1].position;
			start_line_q <= cell_q[1].line;
			name_out_q   <= name_pos_q;
			file_tag_q   <= file_number;
		end
	end

	assign out_valid      = out_valid_q;
	assign tuple_codes    = tuple_q;
	assign value_xor      = xor_q;
	assign start_position = start_pos_q;
	assign start_line     = start_line_q;
	assign name_position  = name_out_q;
	assign file_tag       = file_tag_q;

	// Checks on the window control.
	`ASSERT_ALWAYS(a_fill_bound, fill_q <= ttw_pkg::FILL_W'(N), "fill count above window length")
	`ASSERT_NEXT(a_name_clears, name_tok, (fill_q == '0) && (line_q == ttw_pkg::LINE_W'(1)), "file-name token did not restart the window")
	`ASSERT_NEXT(a_no_emit_short, ord_tok && (fill_q < ttw_pkg::FILL_W'(N - 1)) && !(out_valid_q && !out_ready), !out_valid_q, "result from a window that is not full")
	`ASSERT_ALWAYS(a_ready_when_empty, out_valid_q || in_ready, "input stalled with no result pending")

endmodule
